// ----- rtl/sorted_free_list_allocator_defines.svh -----
// Assertion macros shared by the checker of the sorted free-list allocator.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SORTED_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SORTED_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define SFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define SFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`SFLA_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- rtl/sfla_pkg.sv -----
// Package of the sorted free-list allocator: field widths, codes, controller
// state type and the command and status bundles. Depends on nothing.
`default_nettype none

package sfla_pkg;

	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 16;

	localparam int OFF_W  = 12;
	localparam int ELEM_W = 12;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int CMP_W  = PROD_W + 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
	localparam logic [1:0] STATUS_NOT_OWNED = 2'd2;

	localparam int          PADDR_W          = 3;
	localparam logic [2:0]  CFG_FIT_MODE_ADR = 3'd0;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_START,
		ST_AWALK,
		ST_ADEC,
		ST_AREST,
		ST_ACUR,
		ST_APREV,
		ST_FCHK,
		ST_FWALK,
		ST_FNEXT,
		ST_FWB,
		ST_FPREV,
		ST_RESP
	} sfla_state_t;

	typedef struct packed {
		logic capture;
		logic init_mem;
		logic a_start;
		logic a_step;
		logic w_rest;
		logic w_cur;
		logic w_prev;
		logic f_start;
		logic f_check;
		logic f_step;
		logic f_next;
		logic fw_b;
		logic fw_prev;
		logic set_no_fit;
		logic set_not_owned;
		logic load_out;
	} sfla_cmd_t;

	typedef struct packed {
		logic is_free;
		logic alloc_bad;
		logic off_bad;
		logic not_owned;
		logic a_more;
		logic f_more;
		logic found;
		logic split;
	} sfla_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sfla_req_if.sv -----
// Request channel of the allocator: valid/ready handshake with the request word.
// Depends on nothing.
`default_nettype none

interface sfla_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [11:0] element_bytes;
	logic [11:0] element_count;
	logic [11:0] free_offset;

	modport source (output valid, opcode, element_bytes, element_count, free_offset,
		input ready);
	modport sink (input valid, opcode, element_bytes, element_count, free_offset,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/sfla_rsp_if.sv -----
// Response channel of the allocator: valid/ready handshake with the result word.
// Depends on nothing.
`default_nettype none

interface sfla_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] data_offset;
	logic [11:0] granted_bytes;

	modport source (output valid, status, data_offset, granted_bytes, input ready);
	modport sink (input valid, status, data_offset, granted_bytes, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfla_datapath.sv -----
// Datapath of the allocator: header memory, list walk registers, fit selection,
// split and merge arithmetic and the result registers. Depends on sfla_pkg.
`default_nettype none

module sfla_datapath #(
	parameter int ARENA_BYTES  = sfla_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfla_pkg::sfla_cmd_t  cmd,
	output sfla_pkg::sfla_stat_t stat,
	input  logic [1:0]           place_mode,
	input  logic                 in_opcode,
	input  logic [11:0]          in_element_bytes,
	input  logic [11:0]          in_element_count,
	input  logic [11:0]          in_free_offset,
	output logic [1:0]           out_status,
	output logic [11:0]          out_data_offset,
	output logic [11:0]          out_granted_bytes
);
	import sfla_pkg::*;

	localparam int AW    = $clog2(ARENA_BYTES);
	localparam int LW    = AW + 1;
	localparam int EW    = AW + LW;
	localparam int LIMIT = ARENA_BYTES / HEADER_BYTES + 2;
	localparam int SW    = $clog2(LIMIT + 1);

	localparam logic [LW-1:0]    LINK_NIL   = LW'(ARENA_BYTES);
	localparam logic [LW-1:0]    LINK_OWNED = LW'(ARENA_BYTES + 1);
	localparam logic [CMP_W-1:0] HDR_C      = CMP_W'(HEADER_BYTES);
	localparam logic [CMP_W-1:0] ARENA_C    = CMP_W'(ARENA_BYTES);
	localparam logic [AW-1:0]    INIT_SIZE  = AW'(ARENA_BYTES - HEADER_BYTES);

	logic [EW-1:0]     mem_q [ARENA_BYTES];
	logic [EW-1:0]     rd_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [EW-1:0]     wr_data;

	logic              op_q;
	logic [PROD_W-1:0] prod_q;
	logic [OFF_W-1:0]  off_q;
	logic [LW-1:0]     first_free_q;
	logic [LW-1:0]     cur_q;
	logic [SW-1:0]     steps_q;
	logic [AW-1:0]     prev_q;
	logic [AW-1:0]     prev_size_q;
	logic              prev_head_q;
	logic              found_q;
	logic [AW-1:0]     pick_prev_q;
	logic [AW-1:0]     pick_prev_size_q;
	logic              pick_prev_head_q;
	logic [AW-1:0]     pick_cur_q;
	logic [AW-1:0]     pick_size_q;
	logic [LW-1:0]     pick_link_q;
	logic [AW-1:0]     b_q;
	logic [AW-1:0]     bsize_q;
	logic [LW-1:0]     blink_q;
	logic [1:0]        res_status_q;
	logic [11:0]       res_offset_q;
	logic [11:0]       res_granted_q;
	logic [1:0]        out_status_q;
	logic [11:0]       out_offset_q;
	logic [11:0]       out_granted_q;

	logic [AW-1:0]     rd_size;
	logic [LW-1:0]     rd_link;
	logic [OFF_W-1:0]  b_full;
	logic              walk_start;
	logic              walk_step;
	logic [LW-1:0]     nxt_cur;
	logic [SW-1:0]     nxt_steps;
	logic              in_arena;
	logic              under_limit;
	logic              fits;
	logic              take;
	logic              split;
	logic [AW-1:0]     rest_addr;
	logic [AW-1:0]     rest_size;
	logic [AW-1:0]     granted;
	logic [LW-1:0]     new_next;
	logic              r_merge;
	logic              l_merge;

	assign rd_size = rd_q[EW-1:LW];
	assign rd_link = rd_q[LW-1:0];
	assign b_full  = off_q - OFF_W'(HEADER_BYTES);

	assign walk_start  = cmd.a_start | cmd.f_check;
	assign walk_step   = cmd.a_step | cmd.f_step;
	assign nxt_cur     = walk_start ? first_free_q : rd_link;
	assign nxt_steps   = walk_start ? '0 : steps_q + 1'b1;
	assign in_arena    = CMP_W'(nxt_cur) < ARENA_C;
	assign under_limit = nxt_steps < SW'(LIMIT);

	assign fits = CMP_W'(rd_size) >= CMP_W'(prod_q);
	assign take = fits && (!found_q
		|| (place_mode == FIT_BEST && rd_size < pick_size_q)
		|| (place_mode == FIT_WORST && rd_size > pick_size_q));

	assign split     = !(CMP_W'(prod_q) + HDR_C > CMP_W'(pick_size_q));
	assign rest_addr = AW'(CMP_W'(pick_cur_q) + HDR_C + CMP_W'(prod_q));
	assign rest_size = AW'(CMP_W'(pick_size_q) - CMP_W'(prod_q) - HDR_C);
	assign granted   = split ? AW'(prod_q) : pick_size_q;
	assign new_next  = split ? LW'(rest_addr) : pick_link_q;

	assign r_merge = (CMP_W'(cur_q) < ARENA_C)
		&& (CMP_W'(b_q) + HDR_C + CMP_W'(bsize_q) == CMP_W'(cur_q));
	assign l_merge = !prev_head_q
		&& (CMP_W'(prev_q) + HDR_C + CMP_W'(prev_size_q) == CMP_W'(b_q));

	always_comb begin
		stat           = '0;
		stat.is_free   = op_q == OP_FREE;
		stat.alloc_bad = (CMP_W'(prod_q) > ARENA_C)
			|| (place_mode != FIT_FIRST && place_mode != FIT_BEST && place_mode != FIT_WORST);
		stat.off_bad   = (off_q < OFF_W'(HEADER_BYTES)) || (CMP_W'(b_full) >= ARENA_C);
		stat.not_owned = rd_link != LINK_OWNED;
		stat.a_more    = in_arena && under_limit
			&& !(cmd.a_step && place_mode == FIT_FIRST && fits);
		stat.f_more    = in_arena && under_limit && (CMP_W'(nxt_cur) <= CMP_W'(b_q));
		stat.found     = found_q;
		stat.split     = split;
	end

	always_comb begin
		rd_addr = cmd.f_start ? AW'(b_full) : AW'(nxt_cur);
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {INIT_SIZE, LINK_NIL};
		if (cmd.w_rest) begin
			wr_en   = 1'b1;
			wr_addr = rest_addr;
			wr_data = {rest_size, pick_link_q};
		end else if (cmd.w_cur) begin
			wr_en   = 1'b1;
			wr_addr = pick_cur_q;
			wr_data = {granted, LINK_OWNED};
		end else if (cmd.w_prev) begin
			wr_en   = !pick_prev_head_q;
			wr_addr = pick_prev_q;
			wr_data = {pick_prev_size_q, new_next};
		end else if (cmd.fw_b) begin
			wr_en   = 1'b1;
			wr_addr = b_q;
			wr_data = {bsize_q, blink_q};
		end else if (cmd.fw_prev) begin
			wr_en   = !prev_head_q;
			wr_addr = prev_q;
			if (l_merge) begin
				wr_data = {AW'(CMP_W'(prev_size_q) + HDR_C + CMP_W'(bsize_q)), blink_q};
			end else begin
				wr_data = {prev_size_q, LW'(b_q)};
			end
		end else if (cmd.init_mem) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_free_q <= '0;
		end else if (cmd.w_prev && pick_prev_head_q) begin
			first_free_q <= new_next;
		end else if (cmd.fw_prev && prev_head_q) begin
			first_free_q <= LW'(b_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_opcode;
			prod_q <= PROD_W'(in_element_bytes) * PROD_W'(in_element_count);
			off_q  <= in_free_offset;
		end
		if (cmd.f_start) begin
			b_q <= AW'(b_full);
		end
		if (cmd.f_check) begin
			bsize_q <= rd_size;
		end
		if (walk_start || walk_step) begin
			cur_q   <= nxt_cur;
			steps_q <= nxt_steps;
		end
		if (walk_start) begin
			prev_head_q <= 1'b1;
		end
		if (walk_step) begin
			prev_q      <= AW'(cur_q);
			prev_size_q <= rd_size;
			prev_head_q <= 1'b0;
		end
		if (cmd.a_start) begin
			found_q <= 1'b0;
		end
		if (cmd.a_step && take) begin
			found_q          <= 1'b1;
			pick_prev_q      <= prev_q;
			pick_prev_size_q <= prev_size_q;
			pick_prev_head_q <= prev_head_q;
			pick_cur_q       <= AW'(cur_q);
			pick_size_q      <= rd_size;
			pick_link_q      <= rd_link;
		end
		if (cmd.f_next) begin
			if (r_merge) begin
				bsize_q <= AW'(CMP_W'(bsize_q) + HDR_C + CMP_W'(rd_size));
				blink_q <= rd_link;
			end else begin
				blink_q <= cur_q;
			end
		end
		if (cmd.set_no_fit) begin
			res_status_q  <= STATUS_NO_FIT;
			res_offset_q  <= '0;
			res_granted_q <= '0;
		end else if (cmd.set_not_owned) begin
			res_status_q  <= STATUS_NOT_OWNED;
			res_offset_q  <= '0;
			res_granted_q <= '0;
		end else if (cmd.w_prev) begin
			res_status_q  <= STATUS_OK;
			res_offset_q  <= 12'(CMP_W'(pick_cur_q) + HDR_C);
			res_granted_q <= 12'(granted);
		end else if (cmd.fw_prev) begin
			res_status_q  <= STATUS_OK;
			res_offset_q  <= '0;
			res_granted_q <= '0;
		end
		if (cmd.load_out) begin
			out_status_q  <= res_status_q;
			out_offset_q  <= res_offset_q;
			out_granted_q <= res_granted_q;
		end
	end

	assign out_status        = out_status_q;
	assign out_data_offset   = out_offset_q;
	assign out_granted_bytes = out_granted_q;

endmodule

`default_nettype wire

// ----- rtl/sfla_ctrl.sv -----
// Controller of the allocator: sequences the header walks and writes of one
// request and drives the handshakes. Depends on sfla_pkg.
`default_nettype none

module sfla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sfla_pkg::sfla_cmd_t  cmd,
	input  sfla_pkg::sfla_stat_t stat
);
	import sfla_pkg::*;

	sfla_state_t state_q;
	sfla_state_t state_nxt;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_mem = 1'b1;
				state_nxt    = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_START;
				end
			end
			ST_START: begin
				if (stat.is_free) begin
					if (stat.off_bad) begin
						cmd.set_not_owned = 1'b1;
						state_nxt         = ST_RESP;
					end else begin
						cmd.f_start = 1'b1;
						state_nxt   = ST_FCHK;
					end
				end else if (stat.alloc_bad) begin
					cmd.set_no_fit = 1'b1;
					state_nxt      = ST_RESP;
				end else begin
					cmd.a_start = 1'b1;
					state_nxt   = stat.a_more ? ST_AWALK : ST_ADEC;
				end
			end
			ST_AWALK: begin
				cmd.a_step = 1'b1;
				state_nxt  = stat.a_more ? ST_AWALK : ST_ADEC;
			end
			ST_ADEC: begin
				if (!stat.found) begin
					cmd.set_no_fit = 1'b1;
					state_nxt      = ST_RESP;
				end else begin
					state_nxt = stat.split ? ST_AREST : ST_ACUR;
				end
			end
			ST_AREST: begin
				cmd.w_rest = 1'b1;
				state_nxt  = ST_ACUR;
			end
			ST_ACUR: begin
				cmd.w_cur = 1'b1;
				state_nxt = ST_APREV;
			end
			ST_APREV: begin
				cmd.w_prev = 1'b1;
				state_nxt  = ST_RESP;
			end
			ST_FCHK: begin
				if (stat.not_owned) begin
					cmd.set_not_owned = 1'b1;
					state_nxt         = ST_RESP;
				end else begin
					cmd.f_check = 1'b1;
					state_nxt   = stat.f_more ? ST_FWALK : ST_FNEXT;
				end
			end
			ST_FWALK: begin
				cmd.f_step = 1'b1;
				state_nxt  = stat.f_more ? ST_FWALK : ST_FNEXT;
			end
			ST_FNEXT: begin
				cmd.f_next = 1'b1;
				state_nxt  = ST_FWB;
			end
			ST_FWB: begin
				cmd.fw_b  = 1'b1;
				state_nxt = ST_FPREV;
			end
			ST_FPREV: begin
				cmd.fw_prev = 1'b1;
				state_nxt   = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/sorted_free_list_allocator.sv -----
// Top level of the sorted free-list allocator: APB register, controller and
// datapath. Depends on sfla_pkg, sfla_req_if, sfla_rsp_if, sfla_ctrl, sfla_datapath.
`default_nettype none

// Each request word is handled alone, one header memory access per cycle. An
// allocate walks the free list (first fit stops at the first block that fits,
// best and worst fit visit the whole list), writes the split-off rest if any,
// the granted header and the previous link, then loads the result. A free walks
// the free blocks below the released one, merges it with adjacent free blocks,
// writes the headers and loads the result. After reset the block writes the
// initial header and then accepts words. The result register lets a new request
// be accepted while the previous result still waits to be taken.
module sorted_free_list_allocator #(
	parameter int ARENA_BYTES  = sfla_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sfla_req_if.sink                    req,
	sfla_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfla_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import sfla_pkg::*;

	sfla_cmd_t  cmd;
	sfla_stat_t stat;
	logic [1:0] place_mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_mode_q <= FIT_FIRST;
		end else if (psel && penable && pwrite && paddr[2] == CFG_FIT_MODE_ADR[2]) begin
			place_mode_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == CFG_FIT_MODE_ADR[2]) ? {30'd0, place_mode_q} : 32'd0;

	sfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	sfla_datapath #(
		.ARENA_BYTES  (ARENA_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.place_mode        (place_mode_q),
		.in_opcode         (req.opcode),
		.in_element_bytes  (req.element_bytes),
		.in_element_count  (req.element_count),
		.in_free_offset    (req.free_offset),
		.out_status        (rsp.status),
		.out_data_offset   (rsp.data_offset),
		.out_granted_bytes (rsp.granted_bytes)
	);

endmodule

`default_nettype wire

// ----- rtl/sfla_checker.sv -----
// Port-level checker of the sorted free-list allocator and its bind statement.
// Depends on sfla_pkg and sorted_free_list_allocator_defines.svh.
`default_nettype none
`include "sorted_free_list_allocator_defines.svh"

module sfla_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  rsp_status,
	input wire logic [11:0] rsp_data_offset,
	input wire logic [11:0] rsp_granted_bytes
);
	import sfla_pkg::*;

	logic [1:0]  pending_q;
	logic        req_fire;
	logic        rsp_fire;
	logic [25:0] rsp_word;
	logic        rsp_fail;
	logic        rsp_zero;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;
	assign rsp_word = {rsp_status, rsp_data_offset, rsp_granted_bytes};
	assign rsp_fail = rsp_valid && rsp_status != STATUS_OK;
	assign rsp_zero = rsp_data_offset == 12'd0 && rsp_granted_bytes == 12'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, req_fire} - {1'b0, rsp_fire};
		end
	end

	`SFLA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled response word changed")
	`SFLA_ASSERT(a_fail_zero, clk, arst_n, rsp_fail |-> rsp_zero, "failed response carries nonzero fields")
	`SFLA_ASSERT(a_no_orphan, clk, arst_n, rsp_valid |-> (pending_q != 2'd0), "response word without a pending request")
	`SFLA_ASSERT(a_one_open, clk, arst_n, (req_fire && pending_q != 2'd0) |-> rsp_valid, "request accepted while an earlier one is in work")

endmodule

bind sorted_free_list_allocator sfla_port_checker u_sfla_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_data_offset   (rsp.data_offset),
	.rsp_granted_bytes (rsp.granted_bytes)
);

`default_nettype wire

// ----- dv/sfla_checker.sv -----
// Checker of the sorted free-list allocator: watches the request, response and
// register channels, predicts every response word and compares it.
// Depends on sfla_pkg, sfla_req_if and sfla_rsp_if.
`default_nettype none

module sfla_checker
	import sfla_pkg::*;
(
	input  logic                  clk,
	sfla_req_if                   req,
	sfla_rsp_if                   rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output int                    outstanding,
	output int                    errors
);

	localparam int unsigned ARENA = ARENA_BYTES_DEF;
	localparam int unsigned HDR   = HEADER_BYTES_DEF;
	localparam int unsigned NIL   = ARENA;
	localparam int unsigned OWNED = ARENA + 1;
	localparam int unsigned HEAD  = ARENA + 2;
	localparam int unsigned WALK  = ARENA / HDR + 2;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] data_offset;
		logic [11:0] granted_bytes;
	} rsp_word_t;

	int unsigned blk_size [ARENA];
	int unsigned blk_link [ARENA];
	int unsigned head_link;
	logic [1:0]  place_mode;
	rsp_word_t   pending_rsp [$];

	function automatic int unsigned link_of(int unsigned node);
		if (node == HEAD) return head_link;
		if (node < ARENA) return blk_link[node];
		return NIL;
	endfunction

	function automatic int unsigned size_of(int unsigned node);
		return (node < ARENA) ? blk_size[node] : 0;
	endfunction

	task automatic set_link(int unsigned node, int unsigned v);
		if (node == HEAD) head_link = v;
		else if (node < ARENA) blk_link[node] = v;
	endtask

	task automatic write_hdr(int unsigned node, int unsigned sz, int unsigned lk);
		if (node < ARENA) begin
			blk_size[node] = sz;
			blk_link[node] = lk;
		end
	endtask

	task automatic allocate(int unsigned need, output rsp_word_t w);
		int unsigned prev, cur, steps, pick_prev, pick_size, s, whole, nxt, granted, rest;
		bit found, take;
		prev = HEAD; cur = head_link; steps = 0;
		pick_prev = HEAD; pick_size = 0; found = 0;
		w = '0;
		if (need <= ARENA && place_mode <= FIT_WORST) begin
			while (cur < ARENA && steps < WALK) begin
				s = blk_size[cur];
				if (s >= need) begin
					take = !found;
					if (place_mode == FIT_BEST && found && s < pick_size) take = 1;
					if (place_mode == FIT_WORST && found && s > pick_size) take = 1;
					if (take) begin
						found = 1;
						pick_prev = prev;
						pick_size = s;
					end
					if (place_mode == FIT_FIRST) break;
				end
				prev = cur;
				cur = blk_link[cur];
				steps++;
			end
		end
		if (!found) begin
			w.status = STATUS_NO_FIT;
			return;
		end
		cur = link_of(pick_prev);
		whole = size_of(cur);
		nxt = link_of(cur);
		granted = need;
		if (need + HDR > whole) begin
			granted = whole;
		end else begin
			rest = cur + HDR + need;
			write_hdr(rest, whole - need - HDR, nxt);
			nxt = rest;
		end
		write_hdr(cur, granted, OWNED);
		set_link(pick_prev, nxt);
		w.status = STATUS_OK;
		w.data_offset = 12'(cur + HDR);
		w.granted_bytes = 12'(granted);
	endtask

	task automatic free_block(int unsigned off, output rsp_word_t w);
		int unsigned b, prev, cur, steps, nxt;
		w = '0;
		if (off < HDR) begin
			w.status = STATUS_NOT_OWNED;
			return;
		end
		b = off - HDR;
		if (b >= ARENA || blk_link[b] != OWNED) begin
			w.status = STATUS_NOT_OWNED;
			return;
		end
		prev = HEAD; cur = head_link; steps = 0;
		while (cur < ARENA && steps < WALK && cur <= b) begin
			prev = cur;
			cur = blk_link[cur];
			steps++;
		end
		nxt = link_of(prev);
		if (nxt < ARENA && b + HDR + blk_size[b] == nxt) begin
			blk_size[b] += HDR + blk_size[nxt];
			blk_link[b] = blk_link[nxt];
		end else begin
			blk_link[b] = nxt;
		end
		set_link(prev, b);
		if (prev < ARENA && prev + HDR + blk_size[prev] == b) begin
			blk_size[prev] += HDR + blk_size[b];
			blk_link[prev] = blk_link[b];
		end
		w.status = STATUS_OK;
	endtask

	initial begin
		foreach (blk_size[i]) begin
			blk_size[i] = 0;
			blk_link[i] = 0;
		end
		blk_size[0] = ARENA - HDR;
		blk_link[0] = NIL;
		head_link = 0;
		place_mode = FIT_FIRST;
		errors = 0;
		outstanding = 0;
	end

	always @(negedge clk) begin
		rsp_word_t w, got;
		if (psel && penable && pwrite && paddr == CFG_FIT_MODE_ADR)
			place_mode = pwdata[1:0];
		if (req.valid === 1'b1 && req.ready === 1'b1) begin
			if (req.opcode == OP_ALLOC)
				allocate(int'(req.element_bytes) * int'(req.element_count), w);
			else
				free_block(int'(req.free_offset), w);
			pending_rsp = {pending_rsp, w};
		end
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got = '{rsp.status, rsp.data_offset, rsp.granted_bytes};
			if (pending_rsp.size() == 0) begin
				$error("response word with no request waiting");
				errors++;
			end else begin
				w = pending_rsp.pop_front();
				if (got.status !== w.status) begin
					$error("status: expected %0d, actual %0d", w.status, got.status);
					errors++;
				end
				if (got.data_offset !== w.data_offset) begin
					$error("data_offset: expected %0d, actual %0d",
						w.data_offset, got.data_offset);
					errors++;
				end
				if (got.granted_bytes !== w.granted_bytes) begin
					$error("granted_bytes: expected %0d, actual %0d",
						w.granted_bytes, got.granted_bytes);
					errors++;
				end
			end
		end
		outstanding = pending_rsp.size();
	end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Top of the allocator testbench: clock, reset, request and register stimulus,
// response stalls and the verdict. Depends on sfla_pkg, the channel
// interfaces, sorted_free_list_allocator and sfla_checker.
`default_nettype none

module tb_top;
	import sfla_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	int                 outstanding;
	int                 errors;

	int tx_idle = 21;
	int rx_idle = 52;
	bit start_hold = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int n_alloc = 0;
	int n_free = 0;
	int n_grant = 0;
	int live_offs [$];
	int freed_offs [$];

	sfla_req_if req ();
	sfla_rsp_if rsp ();

	sorted_free_list_allocator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sfla_checker i_checker (
		.clk         (clk),
		.req         (req),
		.rsp         (rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.errors      (errors)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.opcode = OP_ALLOC;
		req.element_bytes = '0;
		req.element_count = '0;
		req.free_offset = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (start_hold && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= 400;
			rsp.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(negedge clk) begin
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1 && rsp.status == STATUS_OK &&
			rsp.data_offset != 0) begin
			live_offs = {live_offs, int'(rsp.data_offset)};
			n_grant++;
		end
	end

	task automatic send(logic op, logic [11:0] eb, logic [11:0] ec, logic [11:0] fo);
		bit rdy;
		while ($urandom_range(99) < tx_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.element_bytes <= eb;
		req.element_count <= ec;
		req.free_offset <= fo;
		do begin
			@(negedge clk);
			rdy = req.ready;
			@(posedge clk);
		end while (!rdy);
		if (op == OP_ALLOC) n_alloc++;
		else n_free++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_place_mode(logic [1:0] mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_FIT_MODE_ADR;
		pwdata <= {30'd0, mode};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic free_some_live();
		int k;
		int off;
		k = $urandom_range(live_offs.size() - 1);
		off = live_offs[k];
		live_offs.delete(k);
		freed_offs = {freed_offs, off};
		send(OP_FREE, 12'($urandom), 12'($urandom), 12'(off));
	endtask

	task automatic random_item();
		int r;
		int off;
		r = $urandom_range(99);
		if (live_offs.size() > 0 && (r < 40 || (live_offs.size() > 24 && r < 70))) begin
			free_some_live();
		end else if (r < 80) begin
			r = $urandom_range(99);
			if (r < 78)
				send(OP_ALLOC, 12'($urandom_range(1, 48)), 12'($urandom_range(1, 4)),
					12'($urandom));
			else if (r < 86)
				send(OP_ALLOC, (r & 1) ? 12'd0 : 12'($urandom),
					(r & 1) ? 12'($urandom) : 12'd0, 12'($urandom));
			else if (r < 93)
				send(OP_ALLOC, 12'($urandom), 12'($urandom), 12'($urandom));
			else
				send(OP_ALLOC, 12'($urandom_range(200, 1500)), 12'd1, 12'($urandom));
		end else if (r < 88 && freed_offs.size() > 0) begin
			off = freed_offs[$urandom_range(freed_offs.size() - 1)];
			send(OP_FREE, 12'($urandom), 12'($urandom), 12'(off));
		end else begin
			send(OP_FREE, 12'($urandom), 12'($urandom), 12'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		int total;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_place_mode(FIT_FIRST);

		send(OP_ALLOC, 12'd0, 12'd0, 12'd0);
		send(OP_ALLOC, 12'd4095, 12'd4095, 12'hfff);
		send(OP_ALLOC, 12'd16, 12'd1, 12'd0);
		send(OP_ALLOC, 12'd1, 12'd1, 12'd0);
		send(OP_ALLOC, 12'd100, 12'd3, 12'd0);
		send(OP_ALLOC, 12'd64, 12'd2, 12'd0);
		send(OP_FREE, 12'd0, 12'd0, 12'd0);
		send(OP_FREE, 12'd0, 12'd0, 12'd15);
		send(OP_ALLOC, 12'd1, 12'd4095, 12'd0);
		drain();
		send(OP_FREE, 12'd0, 12'd0, 12'(live_offs[2]));
		send(OP_FREE, 12'd0, 12'd0, 12'(live_offs[4]));
		send(OP_FREE, 12'd0, 12'd0, 12'(live_offs[3]));
		send(OP_FREE, 12'd0, 12'd0, 12'(live_offs[3]));
		send(OP_FREE, 12'd0, 12'd0, 12'(live_offs[0]));
		send(OP_FREE, 12'd0, 12'd0, 12'(live_offs[1]));
		drain();
		live_offs.delete();
		send(OP_ALLOC, 12'd3390, 12'd1, 12'd0);
		drain();
		write_place_mode(2'd3);
		send(OP_ALLOC, 12'd1, 12'd1, 12'd0);
		send(OP_ALLOC, 12'd0, 12'd5, 12'd0);
		drain();

		total = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_place_mode(ph == 0 ? FIT_BEST : ph == 1 ? FIT_WORST :
				ph == 2 ? FIT_FIRST : FIT_BEST);
			for (int i = 0; i < 350; i++) begin
				total++;
				tx_idle = (total < 470) ? 21 : (total < 940) ? 52 : 0;
				rx_idle = (total < 470) ? 52 : (total < 940) ? 21 : 0;
				if (total == 300) start_hold = 1;
				random_item();
			end
			drain();
		end
		repeat (200) @(posedge clk);

		$display("Covered %0d allocate and %0d free requests, %0d grants, under all fit modes.",
			n_alloc, n_free, n_grant);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#50000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/sfla_pkg.sv
rtl/sfla_req_if.sv
rtl/sfla_rsp_if.sv
rtl/sfla_datapath.sv
rtl/sfla_ctrl.sv
rtl/sorted_free_list_allocator.sv
rtl/sfla_checker.sv
dv/sfla_checker.sv
dv/tb_top.sv
